// File: design/tlex_pkg.sv
package tlex_pkg;

    // Field widths
    localparam int KIND_W = 5;
    localparam int POS_W  = 16;
    localparam int LEN_W  = 16;
    localparam int CHAR_W = 8;

    // Defaults for the top-level parameters, and the most tokens one byte can yield
    localparam int MAX_TEXT_DEF    = 65536;
    localparam int MAX_RES         = 3;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Lexer modes
    localparam logic [2:0] MODE_IDLE  = 3'd0;
    localparam logic [2:0] MODE_IDENT = 3'd1;
    localparam logic [2:0] MODE_NUM   = 3'd2;
    localparam logic [2:0] MODE_QUOTE = 3'd3;
    localparam logic [2:0] MODE_LIT   = 3'd4;
    localparam logic [2:0] MODE_ERR   = 3'd5;

    // Token kinds
    localparam logic [KIND_W-1:0] KIND_LPAREN   = 5'd0;
    localparam logic [KIND_W-1:0] KIND_RPAREN   = 5'd1;
    localparam logic [KIND_W-1:0] KIND_LBRACKET = 5'd2;
    localparam logic [KIND_W-1:0] KIND_RBRACKET = 5'd3;
    localparam logic [KIND_W-1:0] KIND_COLON    = 5'd4;
    localparam logic [KIND_W-1:0] KIND_COMMA    = 5'd5;
    localparam logic [KIND_W-1:0] KIND_IF       = 5'd6;
    localparam logic [KIND_W-1:0] KIND_THEN     = 5'd7;
    localparam logic [KIND_W-1:0] KIND_ELSE     = 5'd8;
    localparam logic [KIND_W-1:0] KIND_LET      = 5'd9;
    localparam logic [KIND_W-1:0] KIND_UPPER_ID = 5'd10;
    localparam logic [KIND_W-1:0] KIND_LOWER_ID = 5'd11;
    localparam logic [KIND_W-1:0] KIND_INT      = 5'd12;
    localparam logic [KIND_W-1:0] KIND_FLOAT    = 5'd13;
    localparam logic [KIND_W-1:0] KIND_CHAR     = 5'd14;
    localparam logic [KIND_W-1:0] KIND_END      = 5'd15;
    localparam logic [KIND_W-1:0] KIND_ERROR    = 5'd16;

    // Special characters
    localparam logic [CHAR_W-1:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [CHAR_W-1:0] CH_POINT      = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_MINUS      = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_QUOTE      = 8'h27;
    localparam logic [CHAR_W-1:0] CH_LPAREN     = 8'h28;
    localparam logic [CHAR_W-1:0] CH_RPAREN     = 8'h29;
    localparam logic [CHAR_W-1:0] CH_LBRACKET   = 8'h5B;
    localparam logic [CHAR_W-1:0] CH_RBRACKET   = 8'h5D;
    localparam logic [CHAR_W-1:0] CH_COLON      = 8'h3A;
    localparam logic [CHAR_W-1:0] CH_COMMA      = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_SPACE      = 8'h20;

    // Keyword prefixes, first character in the low byte
    localparam logic [31:0] KW_IF   = 32'h0000_6669;
    localparam logic [31:0] KW_THEN = 32'h6E65_6874;
    localparam logic [31:0] KW_ELSE = 32'h6573_6C65;
    localparam logic [31:0] KW_LET  = 32'h0074_656C;

    typedef struct packed {
        logic [2:0]        mode;
        logic [POS_W-1:0]  start;
        logic [LEN_W-1:0]  len;
        logic [31:0]       prefix;
        logic              upper;
        logic              point;
        logic [CHAR_W-1:0] lit;
    } lex_state_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0]  start;
        logic [LEN_W-1:0]  length;
        logic [CHAR_W-1:0] value;
        logic              eot;
    } token_t;

    function automatic logic is_upper(input logic [CHAR_W-1:0] c);
        return (c >= 8'h41) && (c <= 8'h5A);
    endfunction

    function automatic logic is_lower(input logic [CHAR_W-1:0] c);
        return (c >= 8'h61) && (c <= 8'h7A);
    endfunction

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_space(input logic [CHAR_W-1:0] c);
        return (c == CH_SPACE) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    function automatic logic [LEN_W-1:0] sat_inc(input logic [LEN_W-1:0] v);
        return (v == {LEN_W{1'b1}}) ? v : v + 1'b1;
    endfunction

    function automatic logic has_pending(input logic [2:0] mode);
        return (mode == MODE_IDENT) || (mode == MODE_NUM) ||
               (mode == MODE_QUOTE) || (mode == MODE_LIT);
    endfunction

    function automatic logic [KIND_W-1:0] ident_kind(input lex_state_t s);
        logic [KIND_W-1:0] k;
        k = s.upper ? KIND_UPPER_ID : KIND_LOWER_ID;
        if (s.len == LEN_W'(2) && s.prefix == KW_IF)
            k = KIND_IF;
        else if (s.len == LEN_W'(4) && s.prefix == KW_THEN)
            k = KIND_THEN;
        else if (s.len == LEN_W'(4) && s.prefix == KW_ELSE)
            k = KIND_ELSE;
        else if (s.len == LEN_W'(3) && s.prefix == KW_LET)
            k = KIND_LET;
        return k;
    endfunction

    // Token for the pending run held in s
    function automatic token_t flush_token(input lex_state_t s);
        token_t t;
        t.start  = s.start;
        t.length = s.len;
        t.value  = '0;
        t.eot    = 1'b0;
        if (s.mode == MODE_IDENT)
            t.kind = ident_kind(s);
        else if (s.mode == MODE_NUM)
            t.kind = s.point ? KIND_FLOAT : KIND_INT;
        else
        begin
            t.kind  = KIND_CHAR;
            t.value = s.lit;
        end
        return t;
    endfunction

endpackage

// File: design/token_lexer_stream.sv
// A token is written into the output queue by the edge that takes the byte that completes it.
// Throughput, while m_tready is high: one byte per cycle while each byte yields at most
// one token; tokens leave one per cycle from a 4-deep output queue, which takes a byte
// only with room for three tokens, so bytes that complete two or three slow the input.
// Reset: rst_n is asynchronous, active low; it clears the lexer state and the queue.
module token_lexer_stream #(
    parameter int MAX_TEXT    = tlex_pkg::MAX_TEXT_DEF,
    parameter int QUEUE_DEPTH = tlex_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic        s_tlast,   // last_char
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [15:0] token_start, [31:16] token_length,
                                   // [39:32] char_value
    output logic [4:0]  m_tuser,   // [4:0] token_kind
    output logic        m_tlast    // end_of_text
);

    logic             accept;
    logic [1:0]       push_n;
    tlex_pkg::token_t push_tok [tlex_pkg::MAX_RES];
    tlex_pkg::token_t head;
    logic             room;

    assign accept = s_tvalid && s_tready;

    // Lexer state and token generation
    tlex_core #(
        .MAX_TEXT (MAX_TEXT)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .ch        (s_tdata),
        .last_char (s_tlast),
        .push_n    (push_n),
        .push_tok  (push_tok)
    );

    // Output queue
    tlex_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_n     (push_n),
        .push_tok   (push_tok),
        .pop_ready  (m_tready),
        .head_valid (m_tvalid),
        .head       (head),
        .room       (room)
    );

    assign s_tready = room;
    assign m_tdata  = {head.value, head.length, head.start};
    assign m_tuser  = head.kind;
    assign m_tlast  = head.eot;

endmodule

// File: design/tlex_core.sv
module tlex_core #(
    parameter int MAX_TEXT = tlex_pkg::MAX_TEXT_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic [tlex_pkg::CHAR_W-1:0] ch,
    input  logic                        last_char,
    output logic [1:0]                  push_n,
    output tlex_pkg::token_t            push_tok [tlex_pkg::MAX_RES]
);

    localparam logic [tlex_pkg::POS_W-1:0] POS_LIMIT =
        ((MAX_TEXT - 1) < 65535) ? tlex_pkg::POS_W'(MAX_TEXT - 1) : {tlex_pkg::POS_W{1'b1}};

    tlex_pkg::lex_state_t           state_reg, state_next, mid;
    logic [tlex_pkg::POS_W-1:0]     pos_reg, pos_next, pos_inc;
    tlex_pkg::token_t               tok_a, tok_b, tok_c, tok_d, tok_1;
    logic                           emit_a, emit_b, emit_c, do_idle;
    logic                           word_char, num_char;
    logic [1:0]                     n_res;

    // Work out the state after this item and the tokens it completes
    always_comb
    begin
        mid       = state_reg;
        emit_a    = 1'b0;
        emit_b    = 1'b0;
        do_idle   = 1'b0;
        tok_a     = tlex_pkg::flush_token(state_reg);
        tok_b     = '0;
        tok_b.start  = pos_reg;
        tok_b.length = tlex_pkg::LEN_W'(1);
        word_char = tlex_pkg::is_upper(ch) || tlex_pkg::is_lower(ch) ||
                    tlex_pkg::is_digit(ch) || (ch == tlex_pkg::CH_UNDERSCORE);
        num_char  = tlex_pkg::is_digit(ch) || (ch == tlex_pkg::CH_POINT);

        unique case (state_reg.mode)
            tlex_pkg::MODE_IDENT:
            begin
                if (word_char)
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        if (state_reg.len == tlex_pkg::LEN_W'(i))
                            mid.prefix[8*i +: 8] = state_reg.prefix[8*i +: 8] | ch;
                    end
                    mid.len = tlex_pkg::sat_inc(state_reg.len);
                end
                else
                begin
                    emit_a  = 1'b1;
                    do_idle = 1'b1;
                end
            end
            tlex_pkg::MODE_NUM:
            begin
                if (num_char)
                begin
                    if (ch == tlex_pkg::CH_POINT)
                        mid.point = 1'b1;
                    mid.len = tlex_pkg::sat_inc(state_reg.len);
                end
                else
                begin
                    emit_a  = 1'b1;
                    do_idle = 1'b1;
                end
            end
            tlex_pkg::MODE_QUOTE:
            begin
                mid.lit  = ch;
                mid.len  = tlex_pkg::sat_inc(state_reg.len);
                mid.mode = tlex_pkg::MODE_LIT;
            end
            tlex_pkg::MODE_LIT:
            begin
                // closing byte: consume unchecked, then emit the literal
                mid.len  = tlex_pkg::sat_inc(state_reg.len);
                tok_a    = tlex_pkg::flush_token(mid);
                emit_a   = 1'b1;
                mid.mode = tlex_pkg::MODE_IDLE;
            end
            tlex_pkg::MODE_ERR:
            begin
                mid = state_reg;
            end
            default:
            begin
                do_idle = 1'b1;
            end
        endcase

        // Start a token from idle
        if (do_idle)
        begin
            mid.mode = tlex_pkg::MODE_IDLE;
            priority if (ch == tlex_pkg::CH_LPAREN)
            begin
                emit_b     = 1'b1;
                tok_b.kind = tlex_pkg::KIND_LPAREN;
            end
            else if (ch == tlex_pkg::CH_RPAREN)
            begin
                emit_b     = 1'b1;
                tok_b.kind = tlex_pkg::KIND_RPAREN;
            end
            else if (ch == tlex_pkg::CH_LBRACKET)
            begin
                emit_b     = 1'b1;
                tok_b.kind = tlex_pkg::KIND_LBRACKET;
            end
            else if (ch == tlex_pkg::CH_RBRACKET)
            begin
                emit_b     = 1'b1;
                tok_b.kind = tlex_pkg::KIND_RBRACKET;
            end
            else if (ch == tlex_pkg::CH_COLON)
            begin
                emit_b     = 1'b1;
                tok_b.kind = tlex_pkg::KIND_COLON;
            end
            else if (ch == tlex_pkg::CH_COMMA)
            begin
                emit_b     = 1'b1;
                tok_b.kind = tlex_pkg::KIND_COMMA;
            end
            else if (tlex_pkg::is_space(ch))
            begin
                mid.mode = tlex_pkg::MODE_IDLE;
            end
            else if (tlex_pkg::is_upper(ch) || tlex_pkg::is_lower(ch) ||
                     tlex_pkg::is_digit(ch) || (ch == tlex_pkg::CH_MINUS) ||
                     (ch == tlex_pkg::CH_QUOTE))
            begin
                mid.start  = pos_reg;
                mid.len    = tlex_pkg::LEN_W'(1);
                mid.prefix = '0;
                mid.upper  = 1'b0;
                mid.point  = 1'b0;
                mid.lit    = '0;
                if (tlex_pkg::is_upper(ch) || tlex_pkg::is_lower(ch))
                begin
                    mid.mode   = tlex_pkg::MODE_IDENT;
                    mid.prefix = {24'h0, ch};
                    mid.upper  = tlex_pkg::is_upper(ch);
                end
                else if (ch == tlex_pkg::CH_QUOTE)
                    mid.mode = tlex_pkg::MODE_QUOTE;
                else
                    mid.mode = tlex_pkg::MODE_NUM;
            end
            else
            begin
                mid.mode   = tlex_pkg::MODE_ERR;
                emit_b     = 1'b1;
                tok_b.kind = tlex_pkg::KIND_ERROR;
            end
        end

        pos_inc = (pos_reg < POS_LIMIT) ? pos_reg + 1'b1 : pos_reg;

        // Final byte: flush what is pending, then the end token
        emit_c = last_char && tlex_pkg::has_pending(mid.mode);
        tok_c  = tlex_pkg::flush_token(mid);
        tok_d        = '0;
        tok_d.kind   = tlex_pkg::KIND_END;
        tok_d.start  = pos_inc;
        tok_d.eot    = 1'b1;

        // A punctuation or error token and a pending flush never meet
        tok_1 = emit_b ? tok_b : tok_c;

        // Pack the valid tokens to the front
        push_tok[0] = emit_a ? tok_a : ((emit_b || emit_c) ? tok_1 : tok_d);
        push_tok[1] = (emit_a && (emit_b || emit_c)) ? tok_1 : tok_d;
        push_tok[2] = tok_d;
        n_res  = 2'(emit_a) + 2'(emit_b || emit_c) + 2'(last_char);
        push_n = accept ? n_res : 2'd0;

        // Commit on accept; the final byte returns to reset
        state_next = state_reg;
        pos_next   = pos_reg;
        if (accept)
        begin
            if (last_char)
            begin
                state_next = '0;
                pos_next   = '0;
            end
            else
            begin
                state_next = mid;
                pos_next   = pos_inc;
            end
        end
    end

    // Hold lexer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
            pos_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
        end
    end

endmodule

// File: design/tlex_queue.sv
module tlex_queue #(
    parameter int DEPTH = tlex_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [1:0]       push_n,
    input  tlex_pkg::token_t push_tok [tlex_pkg::MAX_RES],
    input  logic             pop_ready,
    output logic             head_valid,
    output tlex_pkg::token_t head,
    output logic             room
);

    localparam int CW = $clog2(DEPTH + 1);

    tlex_pkg::token_t q_reg  [DEPTH];
    tlex_pkg::token_t q_next [DEPTH];
    logic [CW-1:0]    count_reg, count_next, base;
    logic             pop;

    assign head_valid = (count_reg != '0);
    assign head       = q_reg[0];
    assign pop        = head_valid && pop_ready;
    // Room for the largest burst of tokens one item can make
    assign room       = (count_reg <= CW'(DEPTH - tlex_pkg::MAX_RES));

    // Shift out the head, then append new items behind what remains
    always_comb
    begin
        base = count_reg - CW'(pop);
        for (int j = 0; j < DEPTH; j++)
            q_next[j] = q_reg[j];
        if (pop)
        begin
            for (int j = 0; j < DEPTH - 1; j++)
                q_next[j] = q_reg[j + 1];
        end
        for (int i = 0; i < tlex_pkg::MAX_RES; i++)
        begin
            for (int j = 0; j < DEPTH; j++)
            begin
                if ((i < int'(push_n)) && (j == int'(base) + i))
                    q_next[j] = push_tok[i];
            end
        end
        count_next = base + CW'(push_n);
    end

    // Hold queued items
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < DEPTH; j++)
            q_reg[j] <= q_next[j];
    end

    // Track fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

endmodule

// File: design/tlex_checker.sv
module tlex_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [4:0]  m_tuser,
    input logic        m_tlast
);

    // A stalled item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("output item changed while stalled");

    // The final byte always yields at least the end item
    a_end_follows: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> m_tvalid)
        else $error("no item after final byte");

    // End marker only on the end kind, with zero length and value
    a_end_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser == tlex_pkg::KIND_END && m_tdata[39:16] == 24'h0)
        else $error("malformed end item");

    // Only character literals carry a value
    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != tlex_pkg::KIND_CHAR |-> m_tdata[39:32] == 8'h0)
        else $error("value on a non-literal item");

endmodule

bind token_lexer_stream tlex_checker u_tlex_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
